[hw/rtl/hti_pkg.sv]
// Shared constants and types for the heightmap triangle interpolator.
package hti_pkg;

    localparam int MAX_GRID_POINTS_DEF = 64;

    localparam int INDEX_W    = 6;
    localparam int HEIGHT_W   = 16;
    localparam int COORD_W    = 17;
    localparam int GRID_PTS_W = 7;

    localparam logic [GRID_PTS_W-1:0] GRID_PTS_RST = 7'd64;
    localparam logic [COORD_W-1:0]    ONE_Q16      = 17'h10000;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

endpackage

[hw/rtl/hti_req_if.sv]
// Request channel: load or query items with valid/ready handshake.
interface hti_req_if;
    import hti_pkg::*;

    logic                       valid;
    logic                       ready;
    op_t                        op;
    logic [INDEX_W-1:0]         row_index;
    logic [INDEX_W-1:0]         col_index;
    logic signed [HEIGHT_W-1:0] sample_height;
    logic [COORD_W-1:0]         x_pos;
    logic [COORD_W-1:0]         y_pos;

    modport source (
        output valid, op, row_index, col_index, sample_height, x_pos, y_pos,
        input  ready
    );

    modport sink (
        input  valid, op, row_index, col_index, sample_height, x_pos, y_pos,
        output ready
    );
endinterface

[hw/rtl/hti_rsp_if.sv]
// Response channel: interpolated height with valid/ready handshake.
interface hti_rsp_if;
    import hti_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [HEIGHT_W-1:0] height_out;

    modport source (
        output valid, height_out,
        input  ready
    );

    modport sink (
        input  valid, height_out,
        output ready
    );
endinterface

[hw/rtl/heightmap_triangle_interpolator_unit.sv]
// Heightmap triangle interpolator: banked height grid and query pipeline.
//
//  channel    | dir | transfer when          | payload
//  -----------+-----+------------------------+--------------------------------------
//  req        | in  | req.valid & req.ready  | op, row/col index, height, x/y pos
//  rsp        | out | rsp.valid & rsp.ready  | height_out (queries only)
//  cfg        | in  | cfg_we                 | grid_points
//
//  One item per cycle while rsp is not stalled. A query passes stages A, B, C, D
//  and out in turn (scale, cell split, grid read, weight multiply, sum and round).
//  The grid sits in four row/column parity banks, each one write and one read
//  port per cycle, so all corners of a cell are read in the same cycle.
//  Reset clears the pipeline valids and sets grid_points to 64; grid contents
//  stay undefined until loaded and get no clearing pass.
//  A stalled rsp holds the result; earlier stages keep filling bubbles, so
//  req.ready drops only once every stage is full.
module heightmap_triangle_interpolator_unit #(
    parameter int MAX_GRID_POINTS = hti_pkg::MAX_GRID_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hti_pkg::GRID_PTS_W-1:0]  cfg_wdata,
    hti_req_if.sink                         req,
    hti_rsp_if.source                       rsp
);
    import hti_pkg::*;

    localparam int IDX_W      = $clog2(MAX_GRID_POINTS);
    localparam int HW         = (IDX_W > 1) ? IDX_W - 1 : 1;
    localparam int BA_W       = 2 * HW;
    localparam int BANK_DEPTH = 1 << BA_W;
    localparam int SX_W       = COORD_W + IDX_W;
    localparam int PROD_W     = HEIGHT_W + COORD_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam logic [IDX_W-1:0] SPAN_RST =
        (int'(GRID_PTS_RST) > MAX_GRID_POINTS) ? IDX_W'(MAX_GRID_POINTS - 1)
                                               : IDX_W'(int'(GRID_PTS_RST) - 1);

    // ---------------------------------------------------------------
    // Configuration: store span = clamped points - 1
    // ---------------------------------------------------------------
    logic [IDX_W-1:0] span_reg;
    logic [IDX_W-1:0] span_next;

    always_comb
    begin
        priority if (cfg_wdata < GRID_PTS_W'(2))
            span_next = IDX_W'(1);
        else if (int'(cfg_wdata) > MAX_GRID_POINTS)
            span_next = IDX_W'(MAX_GRID_POINTS - 1);
        else
            span_next = IDX_W'(cfg_wdata - GRID_PTS_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            span_reg <= SPAN_RST;
        else if (cfg_we)
            span_reg <= span_next;
    end

    // ---------------------------------------------------------------
    // Stage enables: a stage loads when empty or when its item moves on
    // ---------------------------------------------------------------
    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, out_v_reg;
    logic en_a, en_b, en_c, en_d, en_out;

    assign en_out    = !out_v_reg || rsp.ready;
    assign en_d      = !d_v_reg || en_out;
    assign en_c      = !c_v_reg || en_d;
    assign en_b      = !b_v_reg || en_c;
    assign en_a      = !a_v_reg || en_b;
    assign req.ready = en_a;

    // ---------------------------------------------------------------
    // Stage A: saturate and scale coordinates
    // ---------------------------------------------------------------
    op_t                        a_op_reg;
    logic                       a_ld_ok_reg;
    logic [IDX_W-1:0]           a_row_reg, a_col_reg;
    logic signed [HEIGHT_W-1:0] a_h_reg;
    logic [SX_W-1:0]            a_sx_reg, a_sy_reg;

    logic [COORD_W-1:0] x_sat, y_sat;
    logic [SX_W-1:0]    a_sx_next, a_sy_next;
    logic               a_ld_ok_next;

    always_comb
    begin
        x_sat        = (req.x_pos > ONE_Q16) ? ONE_Q16 : req.x_pos;
        y_sat        = (req.y_pos > ONE_Q16) ? ONE_Q16 : req.y_pos;
        a_sx_next    = SX_W'(x_sat) * SX_W'(span_reg);
        a_sy_next    = SX_W'(y_sat) * SX_W'(span_reg);
        a_ld_ok_next = (int'(req.row_index) < MAX_GRID_POINTS) &&
                       (int'(req.col_index) < MAX_GRID_POINTS);
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_op_reg    <= req.op;
            a_ld_ok_reg <= a_ld_ok_next;
            a_row_reg   <= IDX_W'(req.row_index);
            a_col_reg   <= IDX_W'(req.col_index);
            a_h_reg     <= req.sample_height;
            a_sx_reg    <= a_sx_next;
            a_sy_reg    <= a_sy_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage B: cell index and fraction, far edge lands in last cell
    // ---------------------------------------------------------------
    op_t                        b_op_reg;
    logic                       b_ld_ok_reg;
    logic [IDX_W-1:0]           b_row_reg, b_col_reg;
    logic signed [HEIGHT_W-1:0] b_h_reg;
    logic [IDX_W-1:0]           b_cx_reg, b_cy_reg;
    logic [COORD_W-1:0]         b_fx_reg, b_fy_reg;

    logic [IDX_W:0]     hx, hy;
    logic [IDX_W-1:0]   b_cx_next, b_cy_next;
    logic [COORD_W-1:0] b_fx_next, b_fy_next;

    always_comb
    begin
        hx = a_sx_reg[SX_W-1:16];
        hy = a_sy_reg[SX_W-1:16];
        if (hx >= {1'b0, span_reg})
        begin
            b_cx_next = span_reg - IDX_W'(1);
            b_fx_next = ONE_Q16;
        end
        else
        begin
            b_cx_next = hx[IDX_W-1:0];
            b_fx_next = {1'b0, a_sx_reg[15:0]};
        end
        if (hy >= {1'b0, span_reg})
        begin
            b_cy_next = span_reg - IDX_W'(1);
            b_fy_next = ONE_Q16;
        end
        else
        begin
            b_cy_next = hy[IDX_W-1:0];
            b_fy_next = {1'b0, a_sy_reg[15:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            b_op_reg    <= a_op_reg;
            b_ld_ok_reg <= a_ld_ok_reg;
            b_row_reg   <= a_row_reg;
            b_col_reg   <= a_col_reg;
            b_h_reg     <= a_h_reg;
            b_cx_reg    <= b_cx_next;
            b_cy_reg    <= b_cy_next;
            b_fx_reg    <= b_fx_next;
            b_fy_reg    <= b_fy_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage B -> C: triangle fold, weights, banked grid access.
    // Loads write here and queries read here, so program order holds.
    // ---------------------------------------------------------------
    logic                c_fold_reg;
    logic [1:0]          c_par_reg;
    logic [COORD_W-1:0]  c_wb_reg, c_wx_reg, c_wy_reg;

    logic [COORD_W:0]    s_sum;
    logic                c_fold_next;
    logic [COORD_W-1:0]  c_wb_next, c_wx_next, c_wy_next;

    always_comb
    begin
        s_sum       = {1'b0, b_fx_reg} + {1'b0, b_fy_reg};
        c_fold_next = s_sum > {1'b0, ONE_Q16};
        c_wx_next   = c_fold_next ? (ONE_Q16 - b_fy_reg) : b_fx_reg;
        c_wy_next   = c_fold_next ? (ONE_Q16 - b_fx_reg) : b_fy_reg;
        c_wb_next   = ONE_Q16 - c_wx_next - c_wy_next;
    end

    logic                 rd_en, wr_en;
    logic [1:0]           wr_bank;
    logic [BA_W-1:0]      wr_addr;
    logic [BA_W-1:0]      rd_addr [4];
    logic [IDX_W:0]       cx_ext, cy_ext, cx_p1, cy_p1, wr_row_ext, wr_col_ext;
    logic [IDX_W:0]       bank_row [4];
    logic [IDX_W:0]       bank_col [4];

    assign rd_en = en_c && b_v_reg && (b_op_reg == OP_QUERY);
    assign wr_en = en_c && b_v_reg && (b_op_reg == OP_LOAD) && b_ld_ok_reg;

    always_comb
    begin
        cx_ext     = {1'b0, b_cx_reg};
        cy_ext     = {1'b0, b_cy_reg};
        cx_p1      = cx_ext + (IDX_W+1)'(1);
        cy_p1      = cy_ext + (IDX_W+1)'(1);
        wr_row_ext = {1'b0, b_row_reg};
        wr_col_ext = {1'b0, b_col_reg};
        wr_bank    = {b_row_reg[0], b_col_reg[0]};
        wr_addr    = {wr_row_ext[HW:1], wr_col_ext[HW:1]};
        for (int b = 0; b < 4; b++)
        begin
            // bank b holds rows of parity b[1] and columns of parity b[0]
            bank_row[b] = (b_cx_reg[0] == 1'(b >> 1)) ? cx_ext : cx_p1;
            bank_col[b] = (b_cy_reg[0] == 1'(b))      ? cy_ext : cy_p1;
            rd_addr[b]  = {bank_row[b][HW:1], bank_col[b][HW:1]};
        end
    end

    logic signed [HEIGHT_W-1:0] rd_q [4];

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        logic signed [HEIGHT_W-1:0] mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_bank == 2'(g)))
                mem[wr_addr] <= b_h_reg;
            if (rd_en)
                rd_q[g] <= mem[rd_addr[g]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_fold_reg <= c_fold_next;
            c_par_reg  <= {b_cx_reg[0], b_cy_reg[0]};
            c_wb_reg   <= c_wb_next;
            c_wx_reg   <= c_wx_next;
            c_wy_reg   <= c_wy_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage C -> D: pick corners by parity and weight them
    // ---------------------------------------------------------------
    logic signed [PROD_W-1:0] d_pb_reg, d_pr_reg, d_pd_reg;
    logic [1:0]               sel_base, sel_right, sel_down;

    always_comb
    begin
        sel_base  = c_fold_reg ? ~c_par_reg : c_par_reg;
        sel_right = {~c_par_reg[1], c_par_reg[0]};
        sel_down  = {c_par_reg[1], ~c_par_reg[0]};
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            d_pb_reg <= PROD_W'(rd_q[sel_base])  * PROD_W'($signed({1'b0, c_wb_reg}));
            d_pr_reg <= PROD_W'(rd_q[sel_right]) * PROD_W'($signed({1'b0, c_wx_reg}));
            d_pd_reg <= PROD_W'(rd_q[sel_down])  * PROD_W'($signed({1'b0, c_wy_reg}));
        end
    end

    // ---------------------------------------------------------------
    // Stage D -> out: sum, round half up, drop the Q.16 fraction
    // ---------------------------------------------------------------
    logic signed [ACC_W-1:0]    acc;
    logic signed [HEIGHT_W-1:0] out_h_reg;

    assign acc = ACC_W'(d_pb_reg) + ACC_W'(d_pr_reg) + ACC_W'(d_pd_reg) + ACC_W'(32768);

    always_ff @(posedge clk)
    begin
        if (en_out)
            out_h_reg <= acc[31:16];
    end

    // ---------------------------------------------------------------
    // Valid bits
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            d_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_v_reg <= req.valid;
            if (en_b)
                b_v_reg <= a_v_reg;
            if (en_c)
                c_v_reg <= b_v_reg && (b_op_reg == OP_QUERY);
            if (en_d)
                d_v_reg <= c_v_reg;
            if (en_out)
                out_v_reg <= d_v_reg;
        end
    end

    assign rsp.valid      = out_v_reg;
    assign rsp.height_out = out_h_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        c_v_reg |-> (18'(c_wb_reg) + 18'(c_wx_reg) + 18'(c_wy_reg) == 18'(ONE_Q16)))
        else $error("triangle weights do not sum to one");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (b_v_reg && (b_op_reg == OP_QUERY)) |-> (b_fx_reg <= ONE_Q16 && b_fy_reg <= ONE_Q16))
        else $error("cell offset above one");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (rsp.valid && !rsp.ready))
        else $error("request stalled without a blocked response");

endmodule

[dv/heightmap_triangle_interpolator_unit_tb.sv]
// Testbench for the heightmap triangle interpolator: directed and random loads and queries.
module heightmap_triangle_interpolator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hti_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [GRID_PTS_W-1:0] cfg_wdata;

    hti_req_if req_ch ();
    hti_rsp_if rsp_ch ();

    heightmap_triangle_interpolator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // shadow copy of the height grid and the grid size register
    logic signed [HEIGHT_W-1:0] grid_mem [0:MAX_GRID_POINTS_DEF-1][0:MAX_GRID_POINTS_DEF-1];
    bit                         grid_loaded [0:MAX_GRID_POINTS_DEF-1][0:MAX_GRID_POINTS_DEF-1];
    int unsigned                points_cfg = GRID_PTS_RST;

    logic signed [HEIGHT_W-1:0] pending_heights [$];
    int                         error_count = 0;

    int send_idle_pct   = 0;
    int ready_stall_pct = 0;
    int holdoff_len     = 0;
    int holdoff_requests = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned points_in_use();
        int unsigned p;
        p = points_cfg;
        if (p < 2)
            p = 2;
        if (p > MAX_GRID_POINTS_DEF)
            p = MAX_GRID_POINTS_DEF;
        return p;
    endfunction

    // Q1.16 coordinate -> clamped cell index and Q.16 offset
    function automatic void split_pos(input bit [COORD_W-1:0] pos, input int unsigned span,
                                      output int unsigned cell_idx, output int unsigned frac);
        longint unsigned scaled;
        longint unsigned idx;
        longint unsigned p;
        p = pos;
        if (p > 65536)
            p = 65536;
        scaled = p * span;
        idx = scaled >> 16;
        if (idx > span - 1)
            idx = span - 1;
        cell_idx = int'(idx);
        frac = int'(scaled - (idx << 16));
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] surface_height(input bit [COORD_W-1:0] x,
                                                                  input bit [COORD_W-1:0] y);
        int unsigned span, xi, yi, xd, yd, s, t;
        longint      base, right, down, acc, biased;
        span = points_in_use() - 1;
        split_pos(x, span, xi, xd);
        split_pos(y, span, yi, yd);
        s = xd + yd;
        // past the diagonal: fold into the upper triangle
        if (s > 65536)
        begin
            t = xd;
            xd = 65536 - yd;
            yd = 65536 - t;
            s = xd + yd;
            base = grid_mem[xi+1][yi+1];
        end
        else
        begin
            base = grid_mem[xi][yi];
        end
        right = grid_mem[xi+1][yi];
        down  = grid_mem[xi][yi+1];
        acc = base * longint'(65536 - s) + right * longint'(xd) + down * longint'(yd);
        // round to nearest, ties toward plus infinity
        biased = acc + 64'sd2147483648 + 64'sd32768;
        return HEIGHT_W'((biased >>> 16) - 32768);
    endfunction

    function automatic bit [COORD_W-1:0] random_coord();
        int unsigned span, k;
        span = points_in_use() - 1;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? ONE_Q16 : '0;
            1: return COORD_W'($urandom_range(65537, 131071));
            2, 3:
            begin
                // on a grid line
                k = $urandom_range(0, span);
                return COORD_W'((k * 65536) / span);
            end
            default: return COORD_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] random_height();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return HEIGHT_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input op_t op, input bit [INDEX_W-1:0] row,
                             input bit [INDEX_W-1:0] col, input logic signed [HEIGHT_W-1:0] h,
                             input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.op            <= op;
        req_ch.row_index     <= row;
        req_ch.col_index     <= col;
        req_ch.sample_height <= h;
        req_ch.x_pos         <= x;
        req_ch.y_pos         <= y;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        if (op == OP_LOAD)
        begin
            grid_mem[row][col]    = h;
            grid_loaded[row][col] = 1'b1;
        end
        else
        begin
            pending_heights.push_back(surface_height(x, y));
        end
    endtask

    task automatic load_sample(input bit [INDEX_W-1:0] row, input bit [INDEX_W-1:0] col,
                               input logic signed [HEIGHT_W-1:0] h);
        send_item(OP_LOAD, row, col, h, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // loads any corner of the cell not yet written, then sends the query
    task automatic query_point(input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y);
        int unsigned span, xi, yi, xd, yd;
        span = points_in_use() - 1;
        split_pos(x, span, xi, xd);
        split_pos(y, span, yi, yd);
        for (int dx = 0; dx < 2; dx++)
            for (int dy = 0; dy < 2; dy++)
                if (!grid_loaded[xi+dx][yi+dy])
                    load_sample(INDEX_W'(xi + dx), INDEX_W'(yi + dy), random_height());
        send_item(OP_QUERY, INDEX_W'($urandom), INDEX_W'($urandom), HEIGHT_W'($urandom), x, y);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_heights.size() != 0)
            @(posedge clk);
        // loads give no result and may still be in flight
        repeat (8) @(posedge clk);
    endtask

    task automatic set_grid_points(input bit [GRID_PTS_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        points_cfg = value;
    endtask

    task automatic test_reset_default();
        query_point('0, '0);
        query_point(ONE_Q16, ONE_Q16);
        query_point(17'd20000, 17'd40000);
    endtask

    task automatic test_triangles_and_rounding();
        set_grid_points(7'd2);
        load_sample(6'd0, 6'd0, 16'sd0);
        load_sample(6'd1, 6'd0, 16'sd1);
        load_sample(6'd0, 6'd1, -16'sd1);
        load_sample(6'd1, 6'd1, 16'sh7fff);
        query_point(17'd32768, 17'd0);         // +0.5 tie
        query_point(17'd0, 17'd32768);         // -0.5 tie
        query_point('0, '0);
        query_point(ONE_Q16, 17'd0);
        query_point(ONE_Q16, ONE_Q16);         // far corner
        query_point(17'h1ffff, 17'h1ffff);     // saturates
        query_point(17'd49152, 17'd49152);     // upper triangle
        query_point(17'd32768, 17'd32768);     // on the diagonal
        load_sample(6'd1, 6'd1, 16'sh8000);
        load_sample(6'd0, 6'd0, 16'sh8000);
        query_point(ONE_Q16, ONE_Q16);
        query_point(17'd10000, 17'd60000);
    endtask

    task automatic test_grid_size_limits();
        bit [GRID_PTS_W-1:0] sizes [4] = '{7'd0, 7'd1, 7'd65, 7'd127};
        foreach (sizes[i])
        begin
            set_grid_points(sizes[i]);
            query_point(ONE_Q16, ONE_Q16);
            query_point(COORD_W'($urandom_range(0, 65536)), COORD_W'($urandom_range(0, 65536)));
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        bit [GRID_PTS_W-1:0] sizes [12] = '{7'd2, 7'd3, 7'd5, 7'd9, 7'd17, 7'd33, 7'd64,
                                           7'd0, 7'd1, 7'd127, 7'd65, 7'd4};
        int unsigned pts;
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        for (int sub = 0; sub < 3; sub++)
        begin
            if ($urandom_range(0, 3) == 0)
                set_grid_points(GRID_PTS_W'($urandom));
            else
                set_grid_points(sizes[$urandom_range(0, 11)]);
            pts = points_in_use();
            for (int n = 0; n < n_items / 3; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        load_sample(INDEX_W'($urandom_range(0, pts - 1)),
                                    INDEX_W'($urandom_range(0, pts - 1)), random_height());
                    else
                        load_sample(INDEX_W'($urandom), INDEX_W'($urandom), random_height());
                end
                else
                begin
                    query_point(random_coord(), random_coord());
                end
            end
        end
    endtask

    task automatic test_backpressure();
        set_grid_points(7'd4);
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        holdoff_len     = 80;
        holdoff_requests++;
        repeat (40) query_point(random_coord(), random_coord());
    endtask

    // result sink: random stalls plus a long hold-off on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_requests != hold_seen)
            begin
                hold_seen = holdoff_requests;
                hold_left = holdoff_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= ready_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        logic signed [HEIGHT_W-1:0] want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_heights.size() == 0)
            begin
                $error("height_out: no result pending, actual %0d", rsp_ch.height_out);
                error_count++;
            end
            else
            begin
                want = pending_heights.pop_front();
                if (rsp_ch.height_out !== want)
                begin
                    $error("height_out mismatch: expected %0d, actual %0d",
                           want, rsp_ch.height_out);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        req_ch.valid         = 1'b0;
        req_ch.op            = OP_LOAD;
        req_ch.row_index     = '0;
        req_ch.col_index     = '0;
        req_ch.sample_height = '0;
        req_ch.x_pos         = '0;
        req_ch.y_pos         = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_default();
        test_triangles_and_rounding();
        test_grid_size_limits();
        test_random_traffic(0, 0, 450);
        test_random_traffic(76, 0, 450);
        test_random_traffic(0, 76, 450);
        test_random_traffic(6, 6, 450);
        test_backpressure();

        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0 && pending_heights.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
